/* rtl/core/ecpa_pkg.sv */
package ecpa_pkg;

	localparam int FIELD_BITS_DEF = 32;
	localparam int CFG_IDX_W      = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_A  = 2'd1;

	localparam int MODULUS_RST = 3;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL
	} op_t;

	// operand sources and destinations of the datapath
	typedef enum logic [3:0] {
		SEL_ZERO,
		SEL_ONE,
		SEL_THREE,
		SEL_CFGA,
		SEL_X1,
		SEL_Y1,
		SEL_X2,
		SEL_Y2,
		SEL_A,
		SEL_T,
		SEL_NUM,
		SEL_DEN,
		SEL_R,
		SEL_L,
		SEL_X3,
		SEL_Y3
	} sel_t;

	typedef enum logic [2:0] {
		RES_INF_ERR,
		RES_INF,
		RES_P1,
		RES_P2,
		RES_SUM
	} res_t;

	typedef struct packed {
		logic load;
		logic go;
		op_t  op;
		sel_t dst;
		sel_t src_a;
		sel_t src_b;
		logic res_load;
		res_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic inf1;
		logic inf2;
		logic xeq;
		logic yeq;
		logic yopp;
		logic den_zero;
		logic e_bit;
		logic done;
	} sts_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_AMOD,
		S_DBL_SQ,
		S_DBL_3,
		S_DBL_NUM,
		S_DBL_DEN,
		S_CH_NUM,
		S_CH_DEN,
		S_DEN_TEST,
		S_LZERO,
		S_INV_INIT,
		S_INV_SQ,
		S_INV_MUL,
		S_SLOPE,
		S_X_SQ,
		S_X_SUM,
		S_X_RES,
		S_Y_DIF,
		S_Y_MUL,
		S_Y_RES,
		S_FIN,
		S_OUT
	} state_t;

endpackage

/* rtl/core/ecpa_dp.sv */
module ecpa_dp #(
	parameter int FIELD_BITS = ecpa_pkg::FIELD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ecpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_BITS-1:0]          cfg_data,
	input  logic [FIELD_BITS-1:0]          x_first,
	input  logic [FIELD_BITS-1:0]          y_first,
	input  logic                           inf_first,
	input  logic [FIELD_BITS-1:0]          x_second,
	input  logic [FIELD_BITS-1:0]          y_second,
	input  logic                           inf_second,
	input  ecpa_pkg::cmd_t                 cmd,
	input  logic [$clog2(FIELD_BITS)-1:0]  bit_idx,
	output ecpa_pkg::sts_t                 sts,
	output logic [FIELD_BITS-1:0]          x_sum,
	output logic [FIELD_BITS-1:0]          y_sum,
	output logic                           inf_sum,
	output logic                           range_error
);
	import ecpa_pkg::*;

	localparam int W      = FIELD_BITS;
	localparam int MCNT_W = $clog2(W + 1);
	localparam logic [W-1:0] ONE   = W'(1);
	localparam logic [W-1:0] THREE = W'(3);

	function automatic logic [W-1:0] fadd(input logic [W-1:0] p, input logic [W-1:0] q,
			input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, p} + {1'b0, q};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] fsub(input logic [W-1:0] p, input logic [W-1:0] q,
			input logic [W-1:0] m);
		logic [W-1:0] d;
		d = p - q;
		if (p < q) begin
			d = d + m;
		end
		return d;
	endfunction

	logic [W-1:0] mod_q, coefa_q;
	logic [W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic         inf1_q, inf2_q;
	logic [W-1:0] a_q, t_q, num_q, den_q, r_q, l_q, x3_q, y3_q;
	logic [W-1:0] acc_q, mx_q, my_q;
	logic [MCNT_W-1:0] mcnt_q;
	logic         busy_q;
	logic [W-1:0] xo_q, yo_q;
	logic         info_q, erro_q;

	logic [W-1:0] va, vb, alu_res, mul_next, mul_s1, wr_data, e_val;
	logic         mul_start, mul_done, wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q   <= W'(MODULUS_RST);
			coefa_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MODULUS) begin
				mod_q <= cfg_data;
			end else if (cfg_index == CFG_COEF_A) begin
				coefa_q <= cfg_data;
			end
		end
	end

	always_comb begin
		unique case (cmd.src_a)
			SEL_ZERO:  va = '0;
			SEL_ONE:   va = ONE;
			SEL_THREE: va = THREE;
			SEL_CFGA:  va = coefa_q;
			SEL_X1:    va = x1_q;
			SEL_Y1:    va = y1_q;
			SEL_X2:    va = x2_q;
			SEL_Y2:    va = y2_q;
			SEL_A:     va = a_q;
			SEL_T:     va = t_q;
			SEL_NUM:   va = num_q;
			SEL_DEN:   va = den_q;
			SEL_R:     va = r_q;
			SEL_L:     va = l_q;
			SEL_X3:    va = x3_q;
			SEL_Y3:    va = y3_q;
			default:   va = '0;
		endcase
		unique case (cmd.src_b)
			SEL_ZERO:  vb = '0;
			SEL_ONE:   vb = ONE;
			SEL_THREE: vb = THREE;
			SEL_CFGA:  vb = coefa_q;
			SEL_X1:    vb = x1_q;
			SEL_Y1:    vb = y1_q;
			SEL_X2:    vb = x2_q;
			SEL_Y2:    vb = y2_q;
			SEL_A:     vb = a_q;
			SEL_T:     vb = t_q;
			SEL_NUM:   vb = num_q;
			SEL_DEN:   vb = den_q;
			SEL_R:     vb = r_q;
			SEL_L:     vb = l_q;
			SEL_X3:    vb = x3_q;
			SEL_Y3:    vb = y3_q;
			default:   vb = '0;
		endcase
	end

	assign alu_res   = (cmd.op == OP_SUB) ? fsub(va, vb, mod_q) : fadd(va, vb, mod_q);
	// double and add, top multiplier bit first
	assign mul_s1    = fadd(acc_q, acc_q, mod_q);
	assign mul_next  = my_q[W-1] ? fadd(mul_s1, mx_q, mod_q) : mul_s1;
	assign mul_start = cmd.go && !busy_q && (cmd.op == OP_MUL);
	assign mul_done  = busy_q && (mcnt_q == MCNT_W'(1));
	assign wr_en     = mul_done || (cmd.go && !busy_q && (cmd.op != OP_MUL));
	assign wr_data   = busy_q ? mul_next : alu_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mcnt_q <= '0;
		end else if (mul_start) begin
			busy_q <= 1'b1;
			mcnt_q <= MCNT_W'(W);
		end else if (busy_q) begin
			mcnt_q <= mcnt_q - MCNT_W'(1);
			if (mul_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_start) begin
			acc_q <= '0;
			mx_q  <= va;
			my_q  <= vb;
		end else if (busy_q) begin
			acc_q <= mul_next;
			my_q  <= {my_q[W-2:0], 1'b0};
		end
		if (cmd.load) begin
			x1_q   <= x_first;
			y1_q   <= y_first;
			inf1_q <= inf_first;
			x2_q   <= x_second;
			y2_q   <= y_second;
			inf2_q <= inf_second;
		end
		if (wr_en) begin
			unique case (cmd.dst)
				SEL_A:   a_q   <= wr_data;
				SEL_T:   t_q   <= wr_data;
				SEL_NUM: num_q <= wr_data;
				SEL_DEN: den_q <= wr_data;
				SEL_R:   r_q   <= wr_data;
				SEL_L:   l_q   <= wr_data;
				SEL_X3:  x3_q  <= wr_data;
				SEL_Y3:  y3_q  <= wr_data;
				default: ;
			endcase
		end
		if (cmd.res_load) begin
			unique case (cmd.res_sel)
				RES_INF_ERR: begin
					xo_q <= '0; yo_q <= '0; info_q <= 1'b1; erro_q <= 1'b1;
				end
				RES_P1: begin
					xo_q <= x1_q; yo_q <= y1_q; info_q <= 1'b0; erro_q <= 1'b0;
				end
				RES_P2: begin
					xo_q <= x2_q; yo_q <= y2_q; info_q <= 1'b0; erro_q <= 1'b0;
				end
				RES_SUM: begin
					xo_q <= x3_q; yo_q <= y3_q; info_q <= 1'b0; erro_q <= 1'b0;
				end
				default: begin
					xo_q <= '0; yo_q <= '0; info_q <= 1'b1; erro_q <= 1'b0;
				end
			endcase
		end
	end

	assign e_val = mod_q - W'(2);

	always_comb begin
		sts.bad      = (!inf1_q && (mod_q < THREE || x1_q >= mod_q || y1_q >= mod_q))
			|| (!inf2_q && (mod_q < THREE || x2_q >= mod_q || y2_q >= mod_q));
		sts.inf1     = inf1_q;
		sts.inf2     = inf2_q;
		sts.xeq      = (x1_q == x2_q);
		sts.yeq      = (y1_q == y2_q);
		sts.yopp     = (fadd(y1_q, y2_q, mod_q) == '0);
		sts.den_zero = (den_q == '0);
		sts.e_bit    = e_val[bit_idx];
		sts.done     = wr_en;
	end

	assign x_sum       = xo_q;
	assign y_sum       = yo_q;
	assign inf_sum     = info_q;
	assign range_error = erro_q;

endmodule

/* rtl/core/ecpa_ctrl.sv */
module ecpa_ctrl #(
	parameter int FIELD_BITS = ecpa_pkg::FIELD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  ecpa_pkg::sts_t                sts,
	output ecpa_pkg::cmd_t                cmd,
	output logic [$clog2(FIELD_BITS)-1:0] bit_idx
);
	import ecpa_pkg::*;

	localparam int IDX_W = $clog2(FIELD_BITS);

	state_t state_q, state_d;
	logic [IDX_W-1:0] cnt_q;
	logic cnt_ld, cnt_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_ld) begin
				cnt_q <= IDX_W'(FIELD_BITS - 1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - IDX_W'(1);
			end
		end
	end

	assign bit_idx = cnt_q;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		cnt_ld       = 1'b0;
		cnt_dec      = 1'b0;
		cmd.load     = 1'b0;
		cmd.go       = 1'b0;
		cmd.op       = OP_ADD;
		cmd.dst      = SEL_ZERO;
		cmd.src_a    = SEL_ZERO;
		cmd.src_b    = SEL_ZERO;
		cmd.res_load = 1'b0;
		cmd.res_sel  = RES_SUM;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.res_load = 1'b1;
				state_d      = S_OUT;
				priority if (sts.bad) begin
					cmd.res_sel = RES_INF_ERR;
				end else if (sts.inf1 && sts.inf2) begin
					cmd.res_sel = RES_INF;
				end else if (sts.inf1) begin
					cmd.res_sel = RES_P2;
				end else if (sts.inf2) begin
					cmd.res_sel = RES_P1;
				end else if (sts.xeq && sts.yopp) begin
					cmd.res_sel = RES_INF;
				end else if (sts.xeq && sts.yeq) begin
					cmd.res_load = 1'b0;
					state_d      = S_AMOD;
				end else begin
					cmd.res_load = 1'b0;
					state_d      = S_CH_NUM;
				end
			end
			S_AMOD: begin
				cmd.go = 1'b1; cmd.op = OP_MUL;
				cmd.dst = SEL_A; cmd.src_a = SEL_ONE; cmd.src_b = SEL_CFGA;
				if (sts.done) state_d = S_DBL_SQ;
			end
			S_DBL_SQ: begin
				cmd.go = 1'b1; cmd.op = OP_MUL;
				cmd.dst = SEL_T; cmd.src_a = SEL_X1; cmd.src_b = SEL_X1;
				if (sts.done) state_d = S_DBL_3;
			end
			S_DBL_3: begin
				cmd.go = 1'b1; cmd.op = OP_MUL;
				cmd.dst = SEL_T; cmd.src_a = SEL_T; cmd.src_b = SEL_THREE;
				if (sts.done) state_d = S_DBL_NUM;
			end
			S_DBL_NUM: begin
				cmd.go = 1'b1; cmd.op = OP_ADD;
				cmd.dst = SEL_NUM; cmd.src_a = SEL_T; cmd.src_b = SEL_A;
				state_d = S_DBL_DEN;
			end
			S_DBL_DEN: begin
				cmd.go = 1'b1; cmd.op = OP_ADD;
				cmd.dst = SEL_DEN; cmd.src_a = SEL_Y1; cmd.src_b = SEL_Y1;
				state_d = S_DEN_TEST;
			end
			S_CH_NUM: begin
				cmd.go = 1'b1; cmd.op = OP_SUB;
				cmd.dst = SEL_NUM; cmd.src_a = SEL_Y2; cmd.src_b = SEL_Y1;
				state_d = S_CH_DEN;
			end
			S_CH_DEN: begin
				cmd.go = 1'b1; cmd.op = OP_SUB;
				cmd.dst = SEL_DEN; cmd.src_a = SEL_X2; cmd.src_b = SEL_X1;
				state_d = S_DEN_TEST;
			end
			S_DEN_TEST: begin
				state_d = sts.den_zero ? S_LZERO : S_INV_INIT;
			end
			S_LZERO: begin
				cmd.go = 1'b1; cmd.op = OP_ADD;
				cmd.dst = SEL_L; cmd.src_a = SEL_ZERO; cmd.src_b = SEL_ZERO;
				state_d = S_X_SQ;
			end
			S_INV_INIT: begin
				cmd.go = 1'b1; cmd.op = OP_ADD;
				cmd.dst = SEL_R; cmd.src_a = SEL_ONE; cmd.src_b = SEL_ZERO;
				cnt_ld  = 1'b1;
				state_d = S_INV_SQ;
			end
			S_INV_SQ: begin
				cmd.go = 1'b1; cmd.op = OP_MUL;
				cmd.dst = SEL_R; cmd.src_a = SEL_R; cmd.src_b = SEL_R;
				if (sts.done) begin
					priority if (sts.e_bit) begin
						state_d = S_INV_MUL;
					end else if (cnt_q == '0) begin
						state_d = S_SLOPE;
					end else begin
						cnt_dec = 1'b1;
					end
				end
			end
			S_INV_MUL: begin
				cmd.go = 1'b1; cmd.op = OP_MUL;
				cmd.dst = SEL_R; cmd.src_a = SEL_R; cmd.src_b = SEL_DEN;
				if (sts.done) begin
					if (cnt_q == '0) begin
						state_d = S_SLOPE;
					end else begin
						cnt_dec = 1'b1;
						state_d = S_INV_SQ;
					end
				end
			end
			S_SLOPE: begin
				cmd.go = 1'b1; cmd.op = OP_MUL;
				cmd.dst = SEL_L; cmd.src_a = SEL_NUM; cmd.src_b = SEL_R;
				if (sts.done) state_d = S_X_SQ;
			end
			S_X_SQ: begin
				cmd.go = 1'b1; cmd.op = OP_MUL;
				cmd.dst = SEL_T; cmd.src_a = SEL_L; cmd.src_b = SEL_L;
				if (sts.done) state_d = S_X_SUM;
			end
			S_X_SUM: begin
				cmd.go = 1'b1; cmd.op = OP_ADD;
				cmd.dst = SEL_X3; cmd.src_a = SEL_X1; cmd.src_b = SEL_X2;
				state_d = S_X_RES;
			end
			S_X_RES: begin
				cmd.go = 1'b1; cmd.op = OP_SUB;
				cmd.dst = SEL_X3; cmd.src_a = SEL_T; cmd.src_b = SEL_X3;
				state_d = S_Y_DIF;
			end
			S_Y_DIF: begin
				cmd.go = 1'b1; cmd.op = OP_SUB;
				cmd.dst = SEL_T; cmd.src_a = SEL_X1; cmd.src_b = SEL_X3;
				state_d = S_Y_MUL;
			end
			S_Y_MUL: begin
				cmd.go = 1'b1; cmd.op = OP_MUL;
				cmd.dst = SEL_T; cmd.src_a = SEL_L; cmd.src_b = SEL_T;
				if (sts.done) state_d = S_Y_RES;
			end
			S_Y_RES: begin
				cmd.go = 1'b1; cmd.op = OP_SUB;
				cmd.dst = SEL_Y3; cmd.src_a = SEL_T; cmd.src_b = SEL_Y1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_SUM;
				state_d      = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* rtl/core/elliptic_curve_point_add_top.sv */
// channel  | direction | handshake              | payload
// s_axis   | in        | s_axis_tvalid/tready   | tdata x1,y1,x2,y2  tuser inf1,inf2
// m_axis   | out       | m_axis_tvalid/tready   | tdata x,y  tuser inf,range_error
// cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// one word at a time; a word settled by the checks alone goes from S_CHECK to S_OUT;
// the other words run every product on the one bit-serial multiplier, and a nonzero
// denominator is inverted by raising it to modulus - 2; the block returns to idle
// after each result; reset clears the controller, modulus 3, coef_a 0
// a result held on m_axis stalls the block until taken; cfg is always ready
module elliptic_curve_point_add_top #(
	parameter int FIELD_BITS = ecpa_pkg::FIELD_BITS_DEF,
	localparam int DIN_W  = ((4 * FIELD_BITS + 7) / 8) * 8,
	localparam int DOUT_W = ((2 * FIELD_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [DIN_W-1:0]               s_axis_tdata,  // x_first, y_first, x_second, y_second
	input  logic [1:0]                     s_axis_tuser,  // inf_first, inf_second
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [DOUT_W-1:0]              m_axis_tdata,  // x_sum, y_sum
	output logic [1:0]                     m_axis_tuser,  // inf_sum, range_error
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ecpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_BITS-1:0]          cfg_data
);
	import ecpa_pkg::*;

	localparam int W = FIELD_BITS;

	cmd_t cmd;
	sts_t sts;
	logic [$clog2(W)-1:0] bit_idx;
	logic [W-1:0] x_sum, y_sum;
	logic inf_sum, range_error;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	ecpa_ctrl #(.FIELD_BITS(W)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd),
		.bit_idx   (bit_idx)
	);

	ecpa_dp #(.FIELD_BITS(W)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.x_first     (s_axis_tdata[W-1:0]),
		.y_first     (s_axis_tdata[2*W-1:W]),
		.inf_first   (s_axis_tuser[0]),
		.x_second    (s_axis_tdata[3*W-1:2*W]),
		.y_second    (s_axis_tdata[4*W-1:3*W]),
		.inf_second  (s_axis_tuser[1]),
		.cmd         (cmd),
		.bit_idx     (bit_idx),
		.sts         (sts),
		.x_sum       (x_sum),
		.y_sum       (y_sum),
		.inf_sum     (inf_sum),
		.range_error (range_error)
	);

	assign m_axis_tdata = DOUT_W'({y_sum, x_sum});
	assign m_axis_tuser = {range_error, inf_sum};

endmodule
